/* design/pkh_pkg.sv */
// Package for the polynomial key hash block: widths, reset values, register
// indexes, character codes, the controller state type and the digit map.
// No dependencies; every other file uses it through scoped names.
package pkh_pkg;

  localparam int HASH_W      = 31;              // hash, power, modulus, base
  localparam int CHAR_W      = 8;
  localparam int DIGIT_W     = 7;               // digit values 0..64
  localparam int PROD_W      = 2 * HASH_W;      // full product width
  localparam int RDX_BITS    = 2;               // bits reduced per cycle
  localparam int RED_STEPS   = PROD_W / RDX_BITS;
  localparam int CNT_W       = $clog2(RED_STEPS + 1);
  localparam int CFG_IDX_W   = 1;

  localparam logic [HASH_W-1:0] MODULUS_RESET = 31'd1000000009;
  localparam logic [HASH_W-1:0] BASE_RESET    = 31'd67;

  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE    = 1'd1;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_USCORE = 8'h5F;
  localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_D0    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_D9    = 8'h39;

  localparam logic [DIGIT_W-1:0] DIG_LO_A   = 7'd1;
  localparam logic [DIGIT_W-1:0] DIG_UP_A   = 7'd27;
  localparam logic [DIGIT_W-1:0] DIG_D0     = 7'd53;
  localparam logic [DIGIT_W-1:0] DIG_USCORE = 7'd63;
  localparam logic [DIGIT_W-1:0] DIG_SPACE  = 7'd64;
  localparam logic [DIGIT_W-1:0] DIG_NONE   = 7'd0;

  typedef enum logic {
    ST_IDLE,
    ST_REDUCE
  } state_t;

  // Control into a reduction lane
  typedef struct packed {
    logic start;
  } red_ctrl_t;

  // Status out of a reduction lane
  typedef struct packed {
    logic done;
  } red_stat_t;

  // Map a key byte to its digit; zero marks a byte outside the alphabet
  function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
    logic [DIGIT_W-1:0] d;
    d = DIG_NONE;
    if (c >= CH_LO_A && c <= CH_LO_Z) begin
      d = DIGIT_W'(c - CH_LO_A) + DIG_LO_A;
    end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
      d = DIGIT_W'(c - CH_UP_A) + DIG_UP_A;
    end else if (c >= CH_D0 && c <= CH_D9) begin
      d = DIGIT_W'(c - CH_D0) + DIG_D0;
    end else if (c == CH_USCORE) begin
      d = DIG_USCORE;
    end else if (c == CH_SPACE) begin
      d = DIG_SPACE;
    end
    return d;
  endfunction

endpackage

/* design/pkh_if.sv */
// Valid/ready stream interfaces for key bytes and hash results.
// Depends on pkh_pkg for the payload widths.
interface pkh_char_if;
  logic                         valid;
  logic                         ready;
  logic [pkh_pkg::CHAR_W-1:0]   char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface pkh_hash_if;
  logic                         valid;
  logic                         ready;
  logic [pkh_pkg::HASH_W-1:0]   hash_value;
  logic                         invalid;

  modport source (output valid, output hash_value, output invalid, input ready);
  modport sink   (input valid, input hash_value, input invalid, output ready);
endinterface

/* design/pkh_mod_reduce.sv */
// Digit-serial modular reduction lane: reduces a full product by the modulus,
// two bits per cycle, MSB first. Depends on pkh_pkg.
module pkh_mod_reduce (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pkh_pkg::red_ctrl_t            ctrl,
  input  logic [pkh_pkg::PROD_W-1:0]    operand,
  input  logic [pkh_pkg::HASH_W-1:0]    modulus,
  output pkh_pkg::red_stat_t            stat,
  output logic [pkh_pkg::HASH_W-1:0]    result
);

  localparam int TW = pkh_pkg::HASH_W + pkh_pkg::RDX_BITS;

  logic [pkh_pkg::PROD_W-1:0] shift_r, shift_nxt;
  logic [pkh_pkg::HASH_W-1:0] rem_r, rem_nxt;
  logic [pkh_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                       done_r, done_nxt;

  logic [TW-1:0] trial, m1, m2, m3, sub;

  // Partial remainder stays below the modulus, so one digit in needs at most 3m off
  always_comb begin
    trial = {rem_r, shift_r[pkh_pkg::PROD_W-1 -: pkh_pkg::RDX_BITS]};
    m1    = TW'(modulus);
    m2    = TW'({modulus, 1'b0});
    m3    = m1 + m2;
    priority if (trial >= m3) begin
      sub = m3;
    end else if (trial >= m2) begin
      sub = m2;
    end else if (trial >= m1) begin
      sub = m1;
    end else begin
      sub = '0;
    end
  end

  // Load on start, then shift one digit per cycle
  always_comb begin
    shift_nxt = shift_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    if (ctrl.start) begin
      shift_nxt = operand;
      rem_nxt   = '0;
      cnt_nxt   = pkh_pkg::CNT_W'(pkh_pkg::RED_STEPS);
    end else if (cnt_r != '0) begin
      shift_nxt = shift_r << pkh_pkg::RDX_BITS;
      rem_nxt   = pkh_pkg::HASH_W'(trial - sub);
      cnt_nxt   = cnt_r - 1'b1;
      done_nxt  = (cnt_r == pkh_pkg::CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    shift_r <= shift_nxt;
    rem_r   <= rem_nxt;
  end

  assign stat.done = done_r;
  assign result    = rem_r;

endmodule

/* design/polynomial_key_hash.sv */
// Top level of the polynomial key hash: key byte stream in, hash word out.
// Depends on pkh_pkg, pkh_if (pkh_char_if, pkh_hash_if) and pkh_mod_reduce.
//
// Usage:
//   in_ch carries one key byte per word. Bytes a-z, A-Z, 0-9, '_' and ' '
//   extend the hash; any other byte marks the key invalid. A byte of 0 or
//   10 ends the key and produces one word on out_ch: the hash, or hash 0
//   with invalid set when the key held a bad byte.
//   cfg_we/cfg_index/cfg_wdata write modulus (index 0) and base (index 1);
//   write only while the block is idle. Modulus 0 acts as modulus 1.
// Sequence:
//   An alphabet byte forms the two products from the held state, runs them
//   through the two reduction lanes (62-bit products, two bits a cycle,
//   both lanes in parallel) and then stores the results. Bad bytes and
//   bytes after a bad one bypass the lanes. A terminator's result word is
//   visible the cycle after it is accepted.
// Reset and stall:
//   Reset clears the key state and restores modulus 1000000009 and base 67.
//   The result sits in an output register; while it is not taken, key bytes
//   are still accepted, but a further terminator waits until the slot frees.
module polynomial_key_hash (
  input  logic                            clk,
  input  logic                            rst_n,
  pkh_char_if.sink                        in_ch,
  pkh_hash_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [pkh_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pkh_pkg::HASH_W-1:0]      cfg_wdata
);

  localparam int HW = pkh_pkg::HASH_W;
  localparam int PW = pkh_pkg::PROD_W;
  localparam int DPW = pkh_pkg::DIGIT_W + HW + 1;

  pkh_pkg::state_t state_r, state_nxt;

  logic [HW-1:0] modulus_r, base_r;
  logic [HW-1:0] hash_r, hash_nxt;
  logic [HW-1:0] power_r, power_nxt;
  logic          bad_r, bad_nxt;
  logic          ovalid_r, ovalid_nxt;
  logic [HW-1:0] ohash_r, ohash_nxt;
  logic          oinv_r, oinv_nxt;

  logic [HW-1:0]                   mod_eff;
  logic [pkh_pkg::DIGIT_W-1:0]     digit;
  logic                            is_term, accept, out_free;
  logic [DPW-1:0]                  hash_op;
  logic [PW-1:0]                   power_op;
  pkh_pkg::red_ctrl_t              red_ctrl;
  pkh_pkg::red_stat_t              stat_h, stat_p;
  logic [HW-1:0]                   res_h, res_p;

  // Byte decode and handshake
  assign digit    = pkh_pkg::digit_of(in_ch.char_code);
  assign is_term  = (in_ch.char_code == pkh_pkg::CH_NUL) ||
                    (in_ch.char_code == pkh_pkg::CH_LF);
  assign out_free = !ovalid_r || out_ch.ready;
  assign in_ch.ready = (state_r == pkh_pkg::ST_IDLE) && (!is_term || out_free);
  assign accept   = in_ch.valid && in_ch.ready;
  assign mod_eff  = (modulus_r == '0) ? HW'(1) : modulus_r;

  // Form both products from the held state
  assign hash_op  = DPW'(digit * power_r) + DPW'(hash_r);
  assign power_op = power_r * base_r;

  pkh_mod_reduce u_red_hash (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (red_ctrl),
    .operand (PW'(hash_op)),
    .modulus (mod_eff),
    .stat    (stat_h),
    .result  (res_h)
  );

  pkh_mod_reduce u_red_power (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (red_ctrl),
    .operand (power_op),
    .modulus (mod_eff),
    .stat    (stat_p),
    .result  (res_p)
  );

  // Next state, key state and output slot
  always_comb begin
    state_nxt      = state_r;
    hash_nxt       = hash_r;
    power_nxt      = power_r;
    bad_nxt        = bad_r;
    ovalid_nxt     = ovalid_r && !out_ch.ready;
    ohash_nxt      = ohash_r;
    oinv_nxt       = oinv_r;
    red_ctrl.start = 1'b0;
    unique case (state_r)
      pkh_pkg::ST_IDLE: begin
        if (accept) begin
          priority if (is_term) begin
            ovalid_nxt = 1'b1;
            ohash_nxt  = bad_r ? '0 : hash_r;
            oinv_nxt   = bad_r;
            hash_nxt   = '0;
            power_nxt  = HW'(1);
            bad_nxt    = 1'b0;
          end else if (bad_r) begin
            // drop bytes after a bad one
          end else if (digit == pkh_pkg::DIG_NONE) begin
            bad_nxt = 1'b1;
          end else begin
            red_ctrl.start = 1'b1;
            state_nxt      = pkh_pkg::ST_REDUCE;
          end
        end
      end
      pkh_pkg::ST_REDUCE: begin
        if (stat_h.done && stat_p.done) begin
          hash_nxt  = res_h;
          power_nxt = res_p;
          state_nxt = pkh_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pkh_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= pkh_pkg::ST_IDLE;
      hash_r   <= '0;
      power_r  <= HW'(1);
      bad_r    <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      hash_r   <= hash_nxt;
      power_r  <= power_nxt;
      bad_r    <= bad_nxt;
      ovalid_r <= ovalid_nxt;
    end
    ohash_r <= ohash_nxt;
    oinv_r  <= oinv_nxt;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= pkh_pkg::MODULUS_RESET;
      base_r    <= pkh_pkg::BASE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pkh_pkg::CFG_MODULUS: modulus_r <= cfg_wdata;
        pkh_pkg::CFG_BASE:    base_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign out_ch.valid      = ovalid_r;
  assign out_ch.hash_value = ohash_r;
  assign out_ch.invalid    = oinv_r;

endmodule

/* bench/tb_top.sv */
// Self-checking bench for polynomial_key_hash: random and directed key bytes
// in, hash words checked against a built-in rolling hash predictor.
// Depends on pkh_pkg, pkh_if (pkh_char_if, pkh_hash_if) and the block itself.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 40;
  localparam int MAX_PRINTED   = 40;

  typedef enum {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic [pkh_pkg::CHAR_W-1:0] code;
    bit                wait_drain;  // hold until every hash word has come back
  } key_byte_t;

  typedef struct {
    logic [pkh_pkg::HASH_W-1:0] hash;
    logic                       invalid;
  } hash_word_t;

  logic clk;
  logic rst_n;
  logic                          cfg_we;
  logic [pkh_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [pkh_pkg::HASH_W-1:0]    cfg_wdata;

  pkh_char_if key_ch ();
  pkh_hash_if hash_ch ();

  polynomial_key_hash u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (key_ch),
    .out_ch    (hash_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Stimulus, predictor state and bookkeeping
  key_byte_t                  key_bytes_q[$];
  hash_word_t                 predicted_hashes[$];
  logic [pkh_pkg::HASH_W-1:0] mdl_modulus;
  logic [pkh_pkg::HASH_W-1:0] mdl_base;
  logic [pkh_pkg::HASH_W-1:0] acc_hash;
  logic [pkh_pkg::HASH_W-1:0] acc_power;
  logic                       acc_bad;
  int                src_idle_pct;
  int                snk_stall_pct;
  bit                byte_taken;
  int                mismatches;
  int                keys_checked;
  int                bad_keys_checked;
  int                bytes_queued;
  int                phases_run;

  // Clock and reset
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  // Run limit
  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

  // Map a key byte to its digit, 0 for bytes outside the alphabet
  function automatic logic [pkh_pkg::DIGIT_W-1:0] key_digit(
      input logic [pkh_pkg::CHAR_W-1:0] c);
    int v;
    v = int'(c);
    if (v >= 97 && v <= 122)     return pkh_pkg::DIGIT_W'(v - 96);
    if (v >= 65 && v <= 90)      return pkh_pkg::DIGIT_W'(v - 38);
    if (v >= 48 && v <= 57)      return pkh_pkg::DIGIT_W'(v + 5);
    if (c == pkh_pkg::CH_USCORE) return pkh_pkg::DIG_USCORE;
    if (c == pkh_pkg::CH_SPACE)  return pkh_pkg::DIG_SPACE;
    return pkh_pkg::DIG_NONE;
  endfunction

  function automatic bit is_terminator(input logic [pkh_pkg::CHAR_W-1:0] c);
    return c == pkh_pkg::CH_NUL || c == pkh_pkg::CH_LF;
  endfunction

  // Advance the rolling hash by one accepted key byte
  task automatic absorb_key_byte(input logic [pkh_pkg::CHAR_W-1:0] c);
    logic [pkh_pkg::DIGIT_W-1:0] d;
    longint unsigned             m;
    hash_word_t                  w;
    d = key_digit(c);
    if (is_terminator(c)) begin
      w.invalid = acc_bad;
      w.hash    = acc_bad ? '0 : acc_hash;
      predicted_hashes.push_back(w);
      acc_hash  = '0;
      acc_power = pkh_pkg::HASH_W'(1);
      acc_bad   = 1'b0;
    end else if (!acc_bad) begin
      if (d == pkh_pkg::DIG_NONE) begin
        acc_bad = 1'b1;
      end else begin
        m = (mdl_modulus == '0) ? 64'd1 : 64'(mdl_modulus);
        acc_hash  = pkh_pkg::HASH_W'((64'(acc_hash) + 64'(d) * 64'(acc_power)) % m);
        acc_power = pkh_pkg::HASH_W'((64'(acc_power) * 64'(mdl_base)) % m);
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTED) $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Observe both channels at the rising edge: check hash words, predict on key bytes
  always @(posedge clk) begin : observe
    hash_word_t want;
    byte_taken = rst_n && key_ch.valid && key_ch.ready;
    if (rst_n && hash_ch.valid && hash_ch.ready) begin
      if (predicted_hashes.size() == 0) begin
        report_mismatch($sformatf("unexpected hash word %0d invalid %0b",
                                  hash_ch.hash_value, hash_ch.invalid));
      end else begin
        want = predicted_hashes.pop_front();
        if (hash_ch.hash_value !== want.hash)
          report_mismatch($sformatf("hash_value %0d, want %0d", hash_ch.hash_value, want.hash));
        if (hash_ch.invalid !== want.invalid)
          report_mismatch($sformatf("invalid %0b, want %0b", hash_ch.invalid, want.invalid));
        keys_checked++;
        if (want.invalid) bad_keys_checked++;
      end
    end
    if (byte_taken) absorb_key_byte(key_ch.char_code);
  end

  // Drive key bytes at the falling edge; hold a word until it is taken
  always @(negedge clk) begin : drive_keys
    key_byte_t nxt;
    if (!rst_n) begin
      key_ch.valid <= 1'b0;
    end else if (!key_ch.valid || byte_taken) begin
      if (key_bytes_q.size() != 0 && $urandom_range(99) >= src_idle_pct &&
          !(key_bytes_q[0].wait_drain && predicted_hashes.size() != 0)) begin
        nxt = key_bytes_q.pop_front();
        key_ch.valid     <= 1'b1;
        key_ch.char_code <= nxt.code;
      end else begin
        key_ch.valid <= 1'b0;
      end
    end
  end

  // Stall the hash channel at random
  always @(negedge clk) begin
    hash_ch.ready <= rst_n && ($urandom_range(99) >= snk_stall_pct);
  end

  task automatic push_byte(input logic [pkh_pkg::CHAR_W-1:0] c, input bit drain = 1'b0);
    key_byte_t b;
    b.code       = c;
    b.wait_drain = drain;
    key_bytes_q.push_back(b);
    bytes_queued++;
  endtask

  function automatic logic [pkh_pkg::CHAR_W-1:0] pick_alphabet_byte();
    int k;
    k = $urandom_range(63);
    if (k < 26) return pkh_pkg::CH_LO_A + pkh_pkg::CHAR_W'(k);
    if (k < 52) return pkh_pkg::CH_UP_A + pkh_pkg::CHAR_W'(k - 26);
    if (k < 62) return pkh_pkg::CH_D0 + pkh_pkg::CHAR_W'(k - 52);
    if (k == 62) return pkh_pkg::CH_USCORE;
    return pkh_pkg::CH_SPACE;
  endfunction

  function automatic logic [pkh_pkg::CHAR_W-1:0] pick_bad_byte();
    logic [pkh_pkg::CHAR_W-1:0] c;
    do c = pkh_pkg::CHAR_W'($urandom_range(255));
    while (key_digit(c) != pkh_pkg::DIG_NONE || is_terminator(c));
    return c;
  endfunction

  function automatic logic [pkh_pkg::CHAR_W-1:0] pick_terminator();
    return $urandom_range(1) ? pkh_pkg::CH_LF : pkh_pkg::CH_NUL;
  endfunction

  function automatic logic [pkh_pkg::CHAR_W-1:0] pick_key_tail_byte();
    logic [pkh_pkg::CHAR_W-1:0] c;
    do c = pkh_pkg::CHAR_W'($urandom_range(255));
    while (is_terminator(c));
    return c;
  endfunction

  task automatic write_reg(input logic [pkh_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pkh_pkg::HASH_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == pkh_pkg::CFG_MODULUS) mdl_modulus = val;
    else mdl_base = val;
  endtask

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
      IDLE_SRC:  begin src_idle_pct = 72; snk_stall_pct = 0;  end
      IDLE_SNK:  begin src_idle_pct = 0;  snk_stall_pct = 72; end
      default:   begin src_idle_pct = 19; snk_stall_pct = 19; end
    endcase
  endtask

  // Wait until every queued byte is taken and every hash word has come back
  task automatic wait_drained();
    while (key_bytes_q.size() != 0 || key_ch.valid || predicted_hashes.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly well-formed keys, some with bad bytes, some raw noise
  task automatic queue_random_bytes(input int count);
    int start;
    int len;
    int bad_at;
    int r;
    start = bytes_queued;
    while (bytes_queued - start < count) begin
      r = $urandom_range(99);
      if (r < 75) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(24) : $urandom_range(10);
        for (int i = 0; i < len; i++)
          push_byte(pick_alphabet_byte(), i == 0 && $urandom_range(59) == 0);
        push_byte(pick_terminator());
      end else if (r < 90) begin
        len    = $urandom_range(1, 10);
        bad_at = $urandom_range(len - 1);
        for (int i = 0; i < len; i++) begin
          if (i == bad_at) push_byte(pick_bad_byte());
          else if (i > bad_at) push_byte(pick_key_tail_byte());
          else push_byte(pick_alphabet_byte());
        end
        push_byte(pick_terminator());
      end else begin
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++) push_byte(pkh_pkg::CHAR_W'($urandom_range(255)));
      end
    end
  endtask

  task automatic run_phase(input logic [pkh_pkg::HASH_W-1:0] modulus,
                           input logic [pkh_pkg::HASH_W-1:0] base,
                           input idle_mode_t mode, input int count, input bit leave_open);
    wait_drained();
    write_reg(pkh_pkg::CFG_MODULUS, modulus);
    write_reg(pkh_pkg::CFG_BASE, base);
    @(negedge clk);
    cfg_we <= 1'b0;
    set_idling(mode);
    queue_random_bytes(count);
    // leave a partial key so the next modulus applies mid-key
    if (leave_open)
      repeat ($urandom_range(1, 3)) push_byte(pick_alphabet_byte());
    phases_run++;
  endtask

  initial begin
    key_ch.valid     = 1'b0;
    key_ch.char_code = '0;
    hash_ch.ready    = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = pkh_pkg::CFG_MODULUS;
    cfg_wdata        = '0;
    mdl_modulus      = pkh_pkg::MODULUS_RESET;
    mdl_base         = pkh_pkg::BASE_RESET;
    acc_hash         = '0;
    acc_power        = pkh_pkg::HASH_W'(1);
    acc_bad          = 1'b0;
    mismatches       = 0;
    keys_checked     = 0;
    bad_keys_checked = 0;
    bytes_queued     = 0;
    phases_run       = 0;
    byte_taken       = 1'b0;
    set_idling(IDLE_NONE);
    wait (rst_n === 1'b1);

    // Directed keys under the reset settings
    push_byte(pkh_pkg::CH_NUL);                          // empty key
    push_byte(pkh_pkg::CH_LO_A); push_byte(pkh_pkg::CH_LO_Z); push_byte(pkh_pkg::CH_LF);
    push_byte(pkh_pkg::CH_UP_A); push_byte(pkh_pkg::CH_UP_Z);
    push_byte(pkh_pkg::CH_D0); push_byte(pkh_pkg::CH_D9);
    push_byte(pkh_pkg::CH_NUL);
    push_byte(pkh_pkg::CH_USCORE, 1'b1); push_byte(pkh_pkg::CH_SPACE);
    push_byte(pkh_pkg::CH_LF);
    // bad byte, then bytes that must change nothing
    push_byte(pkh_pkg::CH_LO_A); push_byte(8'hFF); push_byte(pkh_pkg::CH_LO_A + 8'd1);
    push_byte(pkh_pkg::CH_LF);
    push_byte(pkh_pkg::CH_LO_A - 8'd1); push_byte(pkh_pkg::CH_NUL);
    push_byte(pkh_pkg::CH_LO_Z + 8'd1); push_byte(pkh_pkg::CH_LF);
    push_byte(pkh_pkg::CH_D9 + 8'd1); push_byte(pkh_pkg::CH_NUL);
    set_idling(IDLE_NONE);
    queue_random_bytes(180);
    phases_run++;

    run_phase(31'h7FFF_FFFF, 31'h7FFF_FFFE, IDLE_SRC, 300, 1'b1);
    run_phase(31'd2, 31'd1, IDLE_SNK, 250, 1'b0);
    run_phase('0, 31'd67, IDLE_BOTH, 150, 1'b1);          // modulus zero acts as one
    run_phase(31'd1, 31'd5, IDLE_NONE, 100, 1'b0);
    run_phase(31'd1000, 31'd5000, IDLE_SRC, 250, 1'b1);   // base above modulus
    run_phase(pkh_pkg::HASH_W'($urandom_range(32'h7FFF_FFFF, 2)),
              pkh_pkg::HASH_W'($urandom_range(32'h7FFF_FFFE, 1)), IDLE_SNK, 300, 1'b0);
    run_phase(31'd97, 31'h7FFF_FFFE, IDLE_BOTH, 300, 1'b1);
    run_phase(pkh_pkg::MODULUS_RESET, pkh_pkg::BASE_RESET, IDLE_NONE, 150, 1'b0);
    push_byte(pkh_pkg::CH_LF);                            // close any open key
    wait_drained();

    $display("tb: %0d key bytes over %0d settings, %0d hash words checked (%0d invalid)",
             bytes_queued, phases_run, keys_checked, bad_keys_checked);
    $display("tb: %0d mismatches", mismatches);
    if (mismatches == 0 && predicted_hashes.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
